>>> src/ami_pkg.sv
// Shared constants and types for the affine matrix inverse pipeline.
package ami_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 64;
   localparam int DEN_W     = 64;
   localparam int QBITS     = 32;
   localparam int NUM_W     = (63 + FRAC_BITS > 32 + 2 * FRAC_BITS) ?
                              63 + FRAC_BITS : 32 + 2 * FRAC_BITS;
   localparam int LANE_LAT  = QBITS + 3;
   localparam int NUM_LANES = 6;

   localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [QBITS:0] LIM_NEG =
      {{(QBITS-DATA_W+1){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [QBITS:0] LIM_POS = LIM_NEG - 1'b1;

   typedef struct packed {
      logic neg;
      logic zero;
   } lane_ctl_type;

   typedef struct packed {
      logic valid;
      logic invertible;
   } tag_type;

endpackage

>>> src/ami_div_lane.sv
// Pipelined restoring divider lane with rounding and signed saturation.
module ami_div_lane (
   input  logic                                clock,
   input  logic                                enable,
   input  logic [ami_pkg::NUM_W-1:0]           num_mag,
   input  logic [ami_pkg::DEN_W-1:0]           den_mag,
   input  ami_pkg::lane_ctl_type               ctl,
   output logic signed [ami_pkg::DATA_W-1:0]   quotient
);
   import ami_pkg::*;

   logic [DEN_W-1:0]   top_ext;
   logic               ovf_start;

   logic [DEN_W-1:0]   rem_ff  [QBITS+1];
   logic [QBITS-1:0]   q_ff    [QBITS+1];
   logic [DEN_W-1:0]   den_ff  [QBITS+1];
   logic               ovf_ff  [QBITS+1];
   lane_ctl_type       ctl_ff  [QBITS+1];
   logic [QBITS-1:0]   low_ff  [QBITS];

   logic [DEN_W-1:0]   shifted [QBITS];
   logic               take    [QBITS];
   logic [DEN_W-1:0]   rem_in  [QBITS];
   logic [QBITS-1:0]   q_in    [QBITS];
   logic [QBITS-1:0]   low_in  [QBITS];

   logic               rnd;
   logic [QBITS:0]     qr_in;
   logic [QBITS:0]     qr_ff;
   logic               ovf_r_ff;
   lane_ctl_type       ctl_r_ff;
   logic [DATA_W-1:0]  quot_in;
   logic [DATA_W-1:0]  quot_ff;

   // The upper part of the dividend must stay below the divisor, otherwise
   // the quotient does not fit and the result saturates.
   always_comb begin
      top_ext   = DEN_W'(num_mag[NUM_W-1:QBITS]);
      ovf_start = top_ext >= den_mag;
   end

   always_comb begin
      for (int k = 0; k < QBITS; k++) begin
         shifted[k] = {rem_ff[k][DEN_W-2:0], low_ff[k][QBITS-1]};
         take[k]    = shifted[k] >= den_ff[k];
         rem_in[k]  = take[k] ? shifted[k] - den_ff[k] : shifted[k];
         q_in[k]    = {q_ff[k][QBITS-2:0], take[k]};
         low_in[k]  = {low_ff[k][QBITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= top_ext;
         q_ff[0]   <= '0;
         den_ff[0] <= den_mag;
         ovf_ff[0] <= ovf_start;
         ctl_ff[0] <= ctl;
         low_ff[0] <= num_mag[QBITS-1:0];
         for (int k = 0; k < QBITS; k++) begin
            rem_ff[k+1] <= rem_in[k];
            q_ff[k+1]   <= q_in[k];
            den_ff[k+1] <= den_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            ctl_ff[k+1] <= ctl_ff[k];
         end
         for (int k = 0; k < QBITS - 1; k++) begin
            low_ff[k+1] <= low_in[k];
         end
      end
   end

   // Round half away from zero on the magnitude.
   always_comb begin
      rnd   = {rem_ff[QBITS], 1'b0} >= {1'b0, den_ff[QBITS]};
      qr_in = {1'b0, q_ff[QBITS]} + (QBITS+1)'(rnd);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         qr_ff    <= qr_in;
         ovf_r_ff <= ovf_ff[QBITS];
         ctl_r_ff <= ctl_ff[QBITS];
      end
   end

   always_comb begin
      priority if (ctl_r_ff.zero) begin
         quot_in = '0;
      end else if (ctl_r_ff.neg) begin
         quot_in = (ovf_r_ff || qr_ff > LIM_NEG) ? SAT_NEG : DATA_W'(-qr_ff);
      end else begin
         quot_in = (ovf_r_ff || qr_ff > LIM_POS) ? SAT_POS : qr_ff[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quot_ff <= quot_in;
      end
   end

   assign quotient = quot_ff;

endmodule

>>> src/affine_matrix_invert.sv
// Top level of the pipelined 2D affine matrix inverse in signed fixed point.
//
// A request carries the six entries of the matrix [a b c; d e f] in signed
// fixed point with FRAC_BITS fraction bits. Each request gives one response
// with the six entries of the inverse, rounded to nearest and saturated, and
// an invertible flag. A singular matrix gives all zeros with the flag low.
// Both channels move a request when valid is high and stall is low.
// The pipeline takes one request in every cycle while the response side does
// not hold it. A request passes the input, product, difference and magnitude
// stages, then, in each of six divider lanes, an entry stage, a stage for
// each quotient bit, and the rounding and saturation stages, and shows on
// the response ports from the saturation stage.
// When the receiver stalls while a response is waiting, the whole pipeline
// holds and req_stall is raised in the same cycle; nothing is lost or
// repeated. Synchronous reset empties the pipeline; it holds no other state.
module affine_matrix_invert (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ami_pkg::DATA_W-1:0]   req_coef_xx,
   input  logic signed [ami_pkg::DATA_W-1:0]   req_coef_xy,
   input  logic signed [ami_pkg::DATA_W-1:0]   req_offset_x,
   input  logic signed [ami_pkg::DATA_W-1:0]   req_coef_yx,
   input  logic signed [ami_pkg::DATA_W-1:0]   req_coef_yy,
   input  logic signed [ami_pkg::DATA_W-1:0]   req_offset_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ami_pkg::DATA_W-1:0]   rsp_inv_xx,
   output logic signed [ami_pkg::DATA_W-1:0]   rsp_inv_xy,
   output logic signed [ami_pkg::DATA_W-1:0]   rsp_inv_offset_x,
   output logic signed [ami_pkg::DATA_W-1:0]   rsp_inv_yx,
   output logic signed [ami_pkg::DATA_W-1:0]   rsp_inv_yy,
   output logic signed [ami_pkg::DATA_W-1:0]   rsp_inv_offset_y,
   output logic                                rsp_invertible
);
   import ami_pkg::*;

   localparam int LANE_XX = 0;
   localparam int LANE_XY = 1;
   localparam int LANE_OX = 2;
   localparam int LANE_YX = 3;
   localparam int LANE_YY = 4;
   localparam int LANE_OY = 5;

   logic enable;

   // Input stage.
   logic                      v1_ff;
   logic signed [DATA_W-1:0]  a1_ff, b1_ff, c1_ff, d1_ff, e1_ff, f1_ff;

   // Product stage.
   logic                      v2_ff;
   logic signed [PROD_W-1:0]  ae_in, bd_in, bf_in, ce_in, cd_in, af_in;
   logic signed [PROD_W-1:0]  ae_ff, bd_ff, bf_ff, ce_ff, cd_ff, af_ff;
   logic signed [DATA_W-1:0]  a2_ff, b2_ff, d2_ff, e2_ff;

   // Difference stage.
   logic                      v3_ff;
   logic signed [PROD_W-1:0]  det_ff, nox_ff, noy_ff;
   logic signed [DATA_W-1:0]  a3_ff, b3_ff, d3_ff, e3_ff;

   // Magnitude stage.
   logic                      v4_ff;
   logic                      inv4_in, inv4_ff;
   logic                      det_neg;
   logic [DEN_W-1:0]          den_in, den_ff;
   logic [DATA_W-1:0]         mag_a, mag_b, mag_d, mag_e;
   logic [PROD_W-1:0]         mag_ox, mag_oy;
   logic [NUM_W-1:0]          num_in  [NUM_LANES];
   logic [NUM_W-1:0]          num_ff  [NUM_LANES];
   lane_ctl_type              ctl_in  [NUM_LANES];
   lane_ctl_type              ctl_ff  [NUM_LANES];

   tag_type                   tag_ff  [LANE_LAT];
   logic signed [DATA_W-1:0]  quot    [NUM_LANES];

   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   always_ff @(posedge clock) begin
      if (enable) begin
         a1_ff <= req_coef_xx;
         b1_ff <= req_coef_xy;
         c1_ff <= req_offset_x;
         d1_ff <= req_coef_yx;
         e1_ff <= req_coef_yy;
         f1_ff <= req_offset_y;
      end
   end

   always_comb begin
      ae_in = a1_ff * e1_ff;
      bd_in = b1_ff * d1_ff;
      bf_in = b1_ff * f1_ff;
      ce_in = c1_ff * e1_ff;
      cd_in = c1_ff * d1_ff;
      af_in = a1_ff * f1_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ae_ff <= ae_in;
         bd_ff <= bd_in;
         bf_ff <= bf_in;
         ce_ff <= ce_in;
         cd_ff <= cd_in;
         af_ff <= af_in;
         a2_ff <= a1_ff;
         b2_ff <= b1_ff;
         d2_ff <= d1_ff;
         e2_ff <= e1_ff;
      end
   end

   // The determinant and both offset numerators fit in 64 bits exactly.
   always_ff @(posedge clock) begin
      if (enable) begin
         det_ff <= ae_ff - bd_ff;
         nox_ff <= bf_ff - ce_ff;
         noy_ff <= cd_ff - af_ff;
         a3_ff  <= a2_ff;
         b3_ff  <= b2_ff;
         d3_ff  <= d2_ff;
         e3_ff  <= e2_ff;
      end
   end

   always_comb begin
      det_neg = det_ff[PROD_W-1];
      den_in  = det_neg ? DEN_W'(-det_ff) : DEN_W'(det_ff);
      inv4_in = det_ff != '0;
      mag_a   = a3_ff[DATA_W-1] ? DATA_W'(-a3_ff) : DATA_W'(a3_ff);
      mag_b   = b3_ff[DATA_W-1] ? DATA_W'(-b3_ff) : DATA_W'(b3_ff);
      mag_d   = d3_ff[DATA_W-1] ? DATA_W'(-d3_ff) : DATA_W'(d3_ff);
      mag_e   = e3_ff[DATA_W-1] ? DATA_W'(-e3_ff) : DATA_W'(e3_ff);
      mag_ox  = nox_ff[PROD_W-1] ? PROD_W'(-nox_ff) : PROD_W'(nox_ff);
      mag_oy  = noy_ff[PROD_W-1] ? PROD_W'(-noy_ff) : PROD_W'(noy_ff);

      num_in[LANE_XX] = NUM_W'(mag_e) << (2 * FRAC_BITS);
      num_in[LANE_XY] = NUM_W'(mag_b) << (2 * FRAC_BITS);
      num_in[LANE_OX] = NUM_W'(mag_ox) << FRAC_BITS;
      num_in[LANE_YX] = NUM_W'(mag_d) << (2 * FRAC_BITS);
      num_in[LANE_YY] = NUM_W'(mag_a) << (2 * FRAC_BITS);
      num_in[LANE_OY] = NUM_W'(mag_oy) << FRAC_BITS;

      // The off-diagonal entries take the negated coefficient.
      ctl_in[LANE_XX].neg = e3_ff[DATA_W-1] ^ det_neg;
      ctl_in[LANE_XY].neg = (!b3_ff[DATA_W-1] && b3_ff != '0) ^ det_neg;
      ctl_in[LANE_OX].neg = nox_ff[PROD_W-1] ^ det_neg;
      ctl_in[LANE_YX].neg = (!d3_ff[DATA_W-1] && d3_ff != '0) ^ det_neg;
      ctl_in[LANE_YY].neg = a3_ff[DATA_W-1] ^ det_neg;
      ctl_in[LANE_OY].neg = noy_ff[PROD_W-1] ^ det_neg;
      for (int i = 0; i < NUM_LANES; i++) begin
         ctl_in[i].zero = !inv4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         den_ff  <= den_in;
         inv4_ff <= inv4_in;
         for (int i = 0; i < NUM_LANES; i++) begin
            num_ff[i] <= num_in[i];
            ctl_ff[i] <= ctl_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         for (int k = 0; k < LANE_LAT; k++) begin
            tag_ff[k] <= '0;
         end
      end else if (enable) begin
         v1_ff     <= req_valid;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         tag_ff[0] <= '{valid: v4_ff, invertible: inv4_ff};
         for (int k = 0; k < LANE_LAT - 1; k++) begin
            tag_ff[k+1] <= tag_ff[k];
         end
      end
   end

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      ami_div_lane u_lane (
         .clock    (clock),
         .enable   (enable),
         .num_mag  (num_ff[i]),
         .den_mag  (den_ff),
         .ctl      (ctl_ff[i]),
         .quotient (quot[i])
      );
   end

   assign rsp_valid        = tag_ff[LANE_LAT-1].valid;
   assign rsp_invertible   = tag_ff[LANE_LAT-1].invertible;
   assign rsp_inv_xx       = quot[LANE_XX];
   assign rsp_inv_xy       = quot[LANE_XY];
   assign rsp_inv_offset_x = quot[LANE_OX];
   assign rsp_inv_yx       = quot[LANE_YX];
   assign rsp_inv_yy       = quot[LANE_YY];
   assign rsp_inv_offset_y = quot[LANE_OY];

endmodule
